// File: rtl/fpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpid_pkg
// Shared widths, register indexes and unit control types of the PID axis.
// ----------------------------------------------------------------------------
package fpid_pkg;

  localparam int WORD_W = 16;
  localparam int FRAC_W = 7;
  localparam int STEP_W = WORD_W - 1;
  // Products and the divider dividend keep only what the truncated 16-bit
  // result needs: a word plus the fraction bits that are dropped.
  localparam int PROD_W = WORD_W + FRAC_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int IDX_W  = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2,
    REG_STEP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic  start;
    prod_t mcand;
    prod_t mplier;
  } mul_ctrl_t;

  typedef struct packed {
    logic  start;
    logic  neg;
    prod_t mag;
    step_t divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// File: rtl/fpid_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpid_in_if
// Request channel carrying one setpoint and one measured value.
// ----------------------------------------------------------------------------
interface fpid_in_if;
  import fpid_pkg::*;

  logic  valid;
  logic  ready;
  word_t setpoint;
  word_t measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface
`default_nettype wire

// File: rtl/fpid_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpid_out_if
// Result channel carrying the drive value of one axis.
// ----------------------------------------------------------------------------
interface fpid_out_if;
  import fpid_pkg::*;

  logic  valid;
  logic  ready;
  word_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface
`default_nettype wire

// File: rtl/fpid_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpid_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface fpid_cfg_if;
  import fpid_pkg::*;

  logic     valid;
  logic     ready;
  reg_idx_t index;
  word_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fpid_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpid_mul
// Shift-add multiplier, one multiplier bit per cycle, modulo 2^PROD_W.
// ----------------------------------------------------------------------------
module fpid_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  fpid_pkg::mul_ctrl_t  ctrl,
  output fpid_pkg::unit_stat_t stat,
  output fpid_pkg::word_t      term
);
  import fpid_pkg::*;

  prod_t            mcand;
  prod_t            mplier;
  prod_t            acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // Two's complement operands give the right low product bits when taken
  // as unsigned, so no sign handling is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mcand  <= ctrl.mcand;
      mplier <= ctrl.mplier;
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[PROD_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign term      = acc[PROD_W-1:FRAC_W];

endmodule
`default_nettype wire

// File: rtl/fpid_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpid_div
// Restoring divider, one quotient bit per cycle, with sign restored at the end.
// ----------------------------------------------------------------------------
module fpid_div (
  input  logic                 clk,
  input  logic                 rst,
  input  fpid_pkg::div_ctrl_t  ctrl,
  output fpid_pkg::unit_stat_t stat,
  output fpid_pkg::prod_t      quot
);
  import fpid_pkg::*;

  prod_t             q;
  step_t             rem;
  step_t             dvs;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [STEP_W:0]   trial;
  logic              fits;

  assign trial = {rem, q[PROD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The remainder stays below the divisor, so it always fits STEP_W bits.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      q   <= ctrl.mag;
      rem <= '0;
      dvs <= ctrl.divisor;
      neg <= ctrl.neg;
    end else if (busy) begin
      if (fits) begin
        rem <= STEP_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[STEP_W-1:0];
      end
      q <= {q[PROD_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = neg ? (~q + PROD_W'(1)) : q;

endmodule
`default_nettype wire

// File: rtl/fixed_point_pid_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_pid_axis
// One PID axis: serial multiplier for P, I and D terms, serial divider for dt.
// ----------------------------------------------------------------------------
// A request is accepted only when idle, after the last one has finished.
// Each request makes three passes of the shared bit-serial multiplier;
// the divider runs alongside the first one.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active high) clears gains, integral and last error and
// sets the time step to 1.0; the block is ready right after reset.
// ----------------------------------------------------------------------------
module fixed_point_pid_axis (
  input  logic       clk,
  input  logic       rst,
  fpid_cfg_if.sink   cfg,
  fpid_in_if.sink    sample,
  fpid_out_if.source result
);
  import fpid_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_PMUL = 6'b000100,
    S_IMUL = 6'b001000,
    S_DMUL = 6'b010000,
    S_SUM  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  word_t prop_gain;
  word_t integ_gain;
  word_t deriv_gain;
  step_t time_step;
  word_t integ_accum;
  word_t last_error;
  word_t err;
  word_t p_term;
  word_t d_term;

  mul_ctrl_t  mul_ctrl;
  unit_stat_t mul_stat;
  word_t      mul_term;
  div_ctrl_t  div_ctrl;
  unit_stat_t div_stat;
  prod_t      div_quot;

  logic [WORD_W:0]   diff;
  logic [WORD_W:0]   diff_abs;
  logic              accept;
  logic              out_free;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign out_free     = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      time_step  <= STEP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP:  prop_gain  <= cfg.data;
        REG_INTEG: integ_gain <= cfg.data;
        REG_DERIV: deriv_gain <= cfg.data;
        REG_STEP:  time_step  <= cfg.data[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  // Error difference is one bit wider than a word and is never wrapped.
  assign diff     = {err[WORD_W-1], err} - {last_error[WORD_W-1], last_error};
  assign diff_abs = diff[WORD_W] ? (~diff + (WORD_W+1)'(1)) : diff;

  always_comb begin
    div_ctrl.start   = (state == S_LOAD);
    div_ctrl.neg     = diff[WORD_W];
    div_ctrl.mag     = {diff_abs[WORD_W-1:0], FRAC_W'(0)};
    div_ctrl.divisor = (time_step == '0) ? STEP_W'(1) : time_step;
  end

  always_comb begin
    mul_ctrl.start  = 1'b0;
    mul_ctrl.mcand  = {{FRAC_W{prop_gain[WORD_W-1]}}, prop_gain};
    mul_ctrl.mplier = {{FRAC_W{err[WORD_W-1]}}, err};
    case (state)
      S_LOAD: begin
        mul_ctrl.start = 1'b1;
      end
      S_PMUL: begin
        mul_ctrl.start = mul_stat.done;
        mul_ctrl.mcand = {{FRAC_W{integ_gain[WORD_W-1]}}, integ_gain};
      end
      S_IMUL: begin
        mul_ctrl.start  = mul_stat.done;
        mul_ctrl.mcand  = {{FRAC_W{deriv_gain[WORD_W-1]}}, deriv_gain};
        mul_ctrl.mplier = div_quot;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_LOAD;
      S_LOAD:  state_next = S_PMUL;
      S_PMUL:  if (mul_stat.done) state_next = S_IMUL;
      S_IMUL:  if (mul_stat.done) state_next = S_DMUL;
      S_DMUL:  if (mul_stat.done) state_next = S_SUM;
      S_SUM:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      integ_accum  <= '0;
      last_error   <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD) begin
        last_error <= err;
      end
      if (state == S_IMUL && mul_stat.done) begin
        integ_accum <= integ_accum + mul_term;
      end
      if (state == S_SUM && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= sample.setpoint - sample.measured;
    end
    if (state == S_PMUL && mul_stat.done) begin
      p_term <= mul_term;
    end
    if (state == S_DMUL && mul_stat.done) begin
      d_term <= mul_term;
    end
    if (state == S_SUM && out_free) begin
      result.drive <= p_term + integ_accum + d_term;
    end
  end

  fpid_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mul_ctrl),
    .stat (mul_stat),
    .term (mul_term)
  );

  fpid_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat),
    .quot (div_quot)
  );

  // The quotient must be settled before the derivative product starts.
  a_quot_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_IMUL && mul_stat.done) |-> !div_stat.busy)
    else $error("derivative multiply started before the divider finished");

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_ctrl.start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_PMUL || state == S_IMUL || state == S_DMUL))
    else $error("multiplier finished outside a multiply state");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOAD && !mul_stat.busy && !div_stat.busy))
    else $error("request accepted while the units were still running");

endmodule
`default_nettype wire
